@@ design/label_block_sum_accumulator_assert.svh @@
// ----------------------------------------------------------------------------
// label block sum accumulator assertion macros
// shared forms for the concurrent checks of the block, clocked on clk_i and
// disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef LABEL_BLOCK_SUM_ACCUMULATOR_ASSERT_SVH
`define LABEL_BLOCK_SUM_ACCUMULATOR_ASSERT_SVH

// same-cycle implication
`define LBSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LBSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/lbsa_pkg.sv @@
// ----------------------------------------------------------------------------
// lbsa_pkg
// sizes, codes, memory port types and helpers of the label block sum
// accumulator
// ----------------------------------------------------------------------------
package lbsa_pkg;

  localparam int MaxNodes   = 1024;
  localparam int MaxLabels  = 8;
  localparam int WeightBits = 16;

  // port field widths
  localparam int ReqW     = 2;
  localparam int NodeW    = 10;
  localparam int LabelInW = 3;
  localparam int WeightW  = 16;
  localparam int BlockW   = 3;
  localparam int StatusW  = 2;
  localparam int SumW     = 38;
  localparam int PairW    = 21;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 4;

  // derived sizes
  localparam int NodeAw   = $clog2(MaxNodes);
  localparam int LabelW   = $clog2(MaxLabels);
  localparam int NodeDw   = LabelW + 1;
  localparam int CountW   = $clog2(MaxNodes + 1);
  localparam int CntAw    = LabelW;
  localparam int TblDepth = MaxLabels * MaxLabels;
  localparam int TblAw    = $clog2(TblDepth);
  localparam int KW       = $clog2(MaxLabels + 1);
  localparam int ClrDepth = (MaxNodes > TblDepth) ? MaxNodes : TblDepth;
  localparam int ClrW     = $clog2(ClrDepth);
  localparam int ProdW    = 2 * CountW;

  localparam logic [CfgDataW-1:0] LabelsRst = CfgDataW'(8);
  localparam logic                HalveRst  = 1'b1;

  typedef enum logic [ReqW-1:0] {
    REQ_LOAD  = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_READ  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK      = 2'd0,
    STAT_RANGE   = 2'd1,
    STAT_NOLABEL = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LABELS = 2'd0,
    CFG_HALVE  = 2'd1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_LD_OLD,
    ST_LD_DEC,
    ST_LD_INC_RD,
    ST_LD_INC,
    ST_AD_COL,
    ST_AD_CHK,
    ST_AD_WR,
    ST_RD_CA,
    ST_RD_CB,
    ST_RD_FIN,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [KW-1:0] k;
    logic          halve;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [NodeAw-1:0] waddr;
    logic [NodeDw-1:0] wdata;
    logic              re;
    logic [NodeAw-1:0] raddr;
  } node_req_t;

  typedef struct packed {
    logic              we;
    logic [CntAw-1:0]  waddr;
    logic [CountW-1:0] wdata;
    logic              re;
    logic [CntAw-1:0]  raddr;
  } cnt_req_t;

  typedef struct packed {
    logic             we;
    logic [TblAw-1:0] waddr;
    logic [SumW-1:0]  wdata;
    logic             re;
    logic [TblAw-1:0] raddr;
  } tbl_req_t;

  // labels in use, capped at the table size
  function automatic logic [KW-1:0] eff_labels(input logic [CfgDataW-1:0] v);
    if (int'(v) > MaxLabels) begin
      return KW'(MaxLabels);
    end
    return KW'(v);
  endfunction

  function automatic logic [TblAw-1:0] tbl_addr(input logic [LabelW-1:0] la,
                                                input logic [LabelW-1:0] lb);
    return TblAw'(int'(la) * MaxLabels + int'(lb));
  endfunction

endpackage

@@ design/lbsa_ram.sv @@
// ----------------------------------------------------------------------------
// lbsa_ram
// generic single-write, single-read synchronous ram with registered read data
// ----------------------------------------------------------------------------
module lbsa_ram #(
  parameter  int Width = 8,
  parameter  int Depth = 16,
  localparam int Aw    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/lbsa_seq.sv @@
// ----------------------------------------------------------------------------
// lbsa_seq
// request sequencer: walks each request through read, modify and write-back
// of the node, count and block sum memories, and holds the result register
// ----------------------------------------------------------------------------
`include "label_block_sum_accumulator_assert.svh"

module lbsa_seq (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  lbsa_pkg::cfg_t                           cfg_i,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic [lbsa_pkg::ReqW-1:0]                req_type_i,
  input  logic [lbsa_pkg::NodeW-1:0]               node_row_i,
  input  logic [lbsa_pkg::NodeW-1:0]               node_col_i,
  input  logic [lbsa_pkg::LabelInW-1:0]            label_i,
  input  logic signed [lbsa_pkg::WeightW-1:0]      weight_i,
  input  logic [lbsa_pkg::BlockW-1:0]              block_a_i,
  input  logic [lbsa_pkg::BlockW-1:0]              block_b_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic [lbsa_pkg::StatusW-1:0]             status_o,
  output logic signed [lbsa_pkg::SumW-1:0]         block_sum_o,
  output logic [lbsa_pkg::PairW-1:0]               pair_count_o,
  output lbsa_pkg::node_req_t                      node_req_o,
  input  logic [lbsa_pkg::NodeDw-1:0]              node_rdata_i,
  output lbsa_pkg::cnt_req_t                       cnt_req_o,
  input  logic [lbsa_pkg::CountW-1:0]              cnt_rdata_i,
  output lbsa_pkg::tbl_req_t                       tbl_req_o,
  input  logic [lbsa_pkg::SumW-1:0]                tbl_rdata_i
);

  localparam logic signed [lbsa_pkg::SumW-1:0] SumMax =
    {1'b0, {(lbsa_pkg::SumW-1){1'b1}}};
  localparam logic signed [lbsa_pkg::SumW-1:0] SumMin =
    {1'b1, {(lbsa_pkg::SumW-1){1'b0}}};
  localparam logic [lbsa_pkg::PairW-1:0] PairMax = '1;

  lbsa_pkg::state_e state_q, state_d;

  logic [lbsa_pkg::ClrW-1:0]           clr_cnt_q;
  logic                                clr_item_q;
  lbsa_pkg::req_e                      req_q;
  logic [lbsa_pkg::NodeW-1:0]          row_q;
  logic [lbsa_pkg::NodeW-1:0]          col_q;
  logic [lbsa_pkg::LabelInW-1:0]       lab_q;
  logic signed [lbsa_pkg::WeightBits-1:0] w_q;
  logic [lbsa_pkg::BlockW-1:0]         a_q;
  logic [lbsa_pkg::BlockW-1:0]         b_q;
  logic [lbsa_pkg::NodeDw-1:0]         ra_q;
  logic [lbsa_pkg::LabelW-1:0]         lb_q;
  logic signed [lbsa_pkg::SumW-1:0]    sum_q;
  logic [lbsa_pkg::CountW-1:0]         ca_q;
  logic [lbsa_pkg::ProdW-1:0]          prod_q;
  lbsa_pkg::status_e                   res_status_q;
  logic signed [lbsa_pkg::SumW-1:0]    res_sum_q;
  logic [lbsa_pkg::PairW-1:0]          res_pair_q;
  logic                                out_valid_q;
  logic [lbsa_pkg::StatusW-1:0]        out_status_q;
  logic signed [lbsa_pkg::SumW-1:0]    out_sum_q;
  logic [lbsa_pkg::PairW-1:0]          out_pair_q;

  logic                                clr_last;
  logic                                out_free;
  logic                                row_bad, col_bad, lab_bad, blk_bad;
  logic                                va, vb, stale, add_ok;
  logic [lbsa_pkg::LabelW-1:0]         la, lb;
  logic                                diag, halve_now;
  logic signed [lbsa_pkg::SumW:0]      w_ext;
  logic signed [lbsa_pkg::SumW:0]      add_sum;
  logic signed [lbsa_pkg::SumW-1:0]    add_sat;
  logic signed [lbsa_pkg::SumW-1:0]    sum_half;
  logic [lbsa_pkg::CountW-1:0]         factor;
  logic [lbsa_pkg::ProdW-1:0]          pair_half;
  logic [lbsa_pkg::PairW-1:0]          pair_sat;

  assign clr_last = (clr_cnt_q == lbsa_pkg::ClrW'(lbsa_pkg::ClrDepth - 1));
  assign out_free = !out_valid_q || out_ready_i;

  assign row_bad = int'(row_q) >= lbsa_pkg::MaxNodes;
  assign col_bad = int'(col_q) >= lbsa_pkg::MaxNodes;
  assign lab_bad = int'(lab_q) >= int'(cfg_i.k);
  assign blk_bad = (int'(a_q) >= int'(cfg_i.k)) || (int'(b_q) >= int'(cfg_i.k));

  // row node entry is held in ra_q, column node entry is on the read port
  assign va     = ra_q[lbsa_pkg::NodeDw-1];
  assign vb     = node_rdata_i[lbsa_pkg::NodeDw-1];
  assign la     = ra_q[lbsa_pkg::LabelW-1:0];
  assign lb     = node_rdata_i[lbsa_pkg::LabelW-1:0];
  assign stale  = (int'(la) >= int'(cfg_i.k)) || (int'(lb) >= int'(cfg_i.k));
  assign add_ok = va && vb && !stale;

  // saturating accumulate of twice the weight
  assign w_ext   = (lbsa_pkg::SumW+1)'(w_q);
  assign add_sum = $signed({tbl_rdata_i[lbsa_pkg::SumW-1], tbl_rdata_i}) + (w_ext <<< 1);
  always_comb begin
    if (add_sum[lbsa_pkg::SumW] != add_sum[lbsa_pkg::SumW-1]) begin
      add_sat = add_sum[lbsa_pkg::SumW] ? SumMin : SumMax;
    end else begin
      add_sat = add_sum[lbsa_pkg::SumW-1:0];
    end
  end

  assign diag      = (a_q == b_q);
  assign halve_now = diag && cfg_i.halve;
  assign factor    = diag ? ((ca_q == '0) ? '0 : ca_q - lbsa_pkg::CountW'(1)) : cnt_rdata_i;
  assign sum_half  = halve_now ? (sum_q >>> 1) : sum_q;
  assign pair_half = halve_now ? (prod_q >> 1) : prod_q;
  assign pair_sat  = (64'(pair_half) > 64'(PairMax)) ? PairMax : lbsa_pkg::PairW'(pair_half);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lbsa_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_d = clr_item_q ? lbsa_pkg::ST_RESP : lbsa_pkg::ST_IDLE;
        end
      end
      lbsa_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = lbsa_pkg::ST_CHECK;
        end
      end
      lbsa_pkg::ST_CHECK: begin
        unique case (req_q)
          lbsa_pkg::REQ_LOAD:
            state_d = (row_bad || lab_bad) ? lbsa_pkg::ST_RESP : lbsa_pkg::ST_LD_OLD;
          lbsa_pkg::REQ_ADD:
            state_d = (row_bad || col_bad) ? lbsa_pkg::ST_RESP : lbsa_pkg::ST_AD_COL;
          lbsa_pkg::REQ_READ:
            state_d = blk_bad ? lbsa_pkg::ST_RESP : lbsa_pkg::ST_RD_CA;
          lbsa_pkg::REQ_CLEAR:
            state_d = lbsa_pkg::ST_CLEAR;
          default:
            state_d = lbsa_pkg::ST_RESP;
        endcase
      end
      lbsa_pkg::ST_LD_OLD:
        state_d = node_rdata_i[lbsa_pkg::NodeDw-1] ? lbsa_pkg::ST_LD_DEC
                                                   : lbsa_pkg::ST_LD_INC_RD;
      lbsa_pkg::ST_LD_DEC:    state_d = lbsa_pkg::ST_LD_INC_RD;
      lbsa_pkg::ST_LD_INC_RD: state_d = lbsa_pkg::ST_LD_INC;
      lbsa_pkg::ST_LD_INC:    state_d = lbsa_pkg::ST_RESP;
      lbsa_pkg::ST_AD_COL:    state_d = lbsa_pkg::ST_AD_CHK;
      lbsa_pkg::ST_AD_CHK:    state_d = add_ok ? lbsa_pkg::ST_AD_WR : lbsa_pkg::ST_RESP;
      lbsa_pkg::ST_AD_WR:     state_d = lbsa_pkg::ST_RESP;
      lbsa_pkg::ST_RD_CA:     state_d = lbsa_pkg::ST_RD_CB;
      lbsa_pkg::ST_RD_CB:     state_d = lbsa_pkg::ST_RD_FIN;
      lbsa_pkg::ST_RD_FIN:    state_d = lbsa_pkg::ST_RESP;
      lbsa_pkg::ST_RESP: begin
        if (out_free) begin
          state_d = lbsa_pkg::ST_IDLE;
        end
      end
      default: state_d = lbsa_pkg::ST_CLEAR;
    endcase
  end

  // memory requests and handshake
  always_comb begin
    node_req_o = '0;
    cnt_req_o  = '0;
    tbl_req_o  = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      lbsa_pkg::ST_CLEAR: begin
        node_req_o.we    = int'(clr_cnt_q) < lbsa_pkg::MaxNodes;
        node_req_o.waddr = lbsa_pkg::NodeAw'(clr_cnt_q);
        cnt_req_o.we     = int'(clr_cnt_q) < lbsa_pkg::MaxLabels;
        cnt_req_o.waddr  = lbsa_pkg::CntAw'(clr_cnt_q);
        tbl_req_o.we     = int'(clr_cnt_q) < lbsa_pkg::TblDepth;
        tbl_req_o.waddr  = lbsa_pkg::TblAw'(clr_cnt_q);
      end
      lbsa_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      lbsa_pkg::ST_CHECK: begin
        if (req_q == lbsa_pkg::REQ_READ) begin
          tbl_req_o.re    = 1'b1;
          tbl_req_o.raddr = lbsa_pkg::tbl_addr(lbsa_pkg::LabelW'(a_q),
                                               lbsa_pkg::LabelW'(b_q));
          cnt_req_o.re    = 1'b1;
          cnt_req_o.raddr = lbsa_pkg::CntAw'(a_q);
        end else begin
          node_req_o.re    = 1'b1;
          node_req_o.raddr = lbsa_pkg::NodeAw'(row_q);
        end
      end
      lbsa_pkg::ST_LD_OLD: begin
        node_req_o.we    = 1'b1;
        node_req_o.waddr = lbsa_pkg::NodeAw'(row_q);
        node_req_o.wdata = {1'b1, lbsa_pkg::LabelW'(lab_q)};
        cnt_req_o.re     = node_rdata_i[lbsa_pkg::NodeDw-1];
        cnt_req_o.raddr  = node_rdata_i[lbsa_pkg::LabelW-1:0];
      end
      lbsa_pkg::ST_LD_DEC: begin
        cnt_req_o.we    = 1'b1;
        cnt_req_o.waddr = la;
        cnt_req_o.wdata = cnt_rdata_i - lbsa_pkg::CountW'(cnt_rdata_i != '0);
      end
      lbsa_pkg::ST_LD_INC_RD: begin
        cnt_req_o.re    = 1'b1;
        cnt_req_o.raddr = lbsa_pkg::CntAw'(lab_q);
      end
      lbsa_pkg::ST_LD_INC: begin
        cnt_req_o.we    = 1'b1;
        cnt_req_o.waddr = lbsa_pkg::CntAw'(lab_q);
        cnt_req_o.wdata = cnt_rdata_i + lbsa_pkg::CountW'(1);
      end
      lbsa_pkg::ST_AD_COL: begin
        node_req_o.re    = 1'b1;
        node_req_o.raddr = lbsa_pkg::NodeAw'(col_q);
      end
      lbsa_pkg::ST_AD_CHK: begin
        tbl_req_o.re    = add_ok;
        tbl_req_o.raddr = lbsa_pkg::tbl_addr(la, lb);
      end
      lbsa_pkg::ST_AD_WR: begin
        tbl_req_o.we    = 1'b1;
        tbl_req_o.waddr = lbsa_pkg::tbl_addr(la, lb_q);
        tbl_req_o.wdata = add_sat;
      end
      lbsa_pkg::ST_RD_CA: begin
        cnt_req_o.re    = 1'b1;
        cnt_req_o.raddr = lbsa_pkg::CntAw'(b_q);
      end
      lbsa_pkg::ST_RD_CB, lbsa_pkg::ST_RD_FIN, lbsa_pkg::ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lbsa_pkg::ST_CLEAR;
      clr_cnt_q   <= '0;
      clr_item_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == lbsa_pkg::ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + lbsa_pkg::ClrW'(1);
      end else begin
        clr_cnt_q <= '0;
      end
      if (state_q == lbsa_pkg::ST_CHECK) begin
        clr_item_q <= (req_q == lbsa_pkg::REQ_CLEAR);
      end
      if (state_q == lbsa_pkg::ST_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request, working and result registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      lbsa_pkg::ST_CLEAR: begin
        res_status_q <= lbsa_pkg::STAT_OK;
        res_sum_q    <= '0;
        res_pair_q   <= '0;
      end
      lbsa_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          req_q <= lbsa_pkg::req_e'(req_type_i);
          row_q <= node_row_i;
          col_q <= node_col_i;
          lab_q <= label_i;
          w_q   <= $signed(weight_i[lbsa_pkg::WeightBits-1:0]);
          a_q   <= block_a_i;
          b_q   <= block_b_i;
        end
      end
      lbsa_pkg::ST_CHECK: begin
        res_status_q <= lbsa_pkg::STAT_RANGE;
        res_sum_q    <= '0;
        res_pair_q   <= '0;
      end
      lbsa_pkg::ST_LD_OLD, lbsa_pkg::ST_AD_COL: begin
        ra_q <= node_rdata_i;
      end
      lbsa_pkg::ST_LD_INC, lbsa_pkg::ST_AD_WR: begin
        res_status_q <= lbsa_pkg::STAT_OK;
      end
      lbsa_pkg::ST_AD_CHK: begin
        lb_q         <= lb;
        res_status_q <= (!va || !vb) ? lbsa_pkg::STAT_NOLABEL : lbsa_pkg::STAT_RANGE;
      end
      lbsa_pkg::ST_RD_CA: begin
        sum_q <= $signed(tbl_rdata_i);
        ca_q  <= cnt_rdata_i;
      end
      lbsa_pkg::ST_RD_CB: begin
        prod_q <= lbsa_pkg::ProdW'(ca_q) * lbsa_pkg::ProdW'(factor);
      end
      lbsa_pkg::ST_RD_FIN: begin
        res_status_q <= lbsa_pkg::STAT_OK;
        res_sum_q    <= sum_half;
        res_pair_q   <= pair_sat;
      end
      lbsa_pkg::ST_RESP: begin
        if (out_free) begin
          out_status_q <= res_status_q;
          out_sum_q    <= res_sum_q;
          out_pair_q   <= res_pair_q;
        end
      end
      lbsa_pkg::ST_LD_DEC, lbsa_pkg::ST_LD_INC_RD: begin
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign block_sum_o  = out_sum_q;
  assign pair_count_o = out_pair_q;

  `LBSA_ASSERT_NXT(a_accept_to_check, in_valid_i && in_ready_o, state_q == lbsa_pkg::ST_CHECK, "transfer not followed by check")
  `LBSA_ASSERT_IMP(a_tbl_wr_after_lookup, tbl_req_o.we && state_q != lbsa_pkg::ST_CLEAR, $past(state_q) == lbsa_pkg::ST_AD_CHK, "table write without lookup")
  `LBSA_ASSERT_IMP(a_node_wr_sets_label, node_req_o.we && state_q != lbsa_pkg::ST_CLEAR, node_req_o.wdata[lbsa_pkg::NodeDw-1], "node write outside clear without label")
  `LBSA_ASSERT_NXT(a_result_loaded, state_q == lbsa_pkg::ST_RESP && out_free, out_valid_q, "result not presented")

endmodule

@@ design/label_block_sum_accumulator.sv @@
// ----------------------------------------------------------------------------
// label_block_sum_accumulator
// node labels, per-label member counts and a label by label table of summed
// edge weights, all held in synchronous memories
// ----------------------------------------------------------------------------
//   channel  | signals                                   | accepted when
//   ---------+-------------------------------------------+----------------------
//   request  | in_valid_i / in_ready_o, req_type_i..     | in_valid_i & in_ready_o
//   result   | out_valid_o / out_ready_i, status_o..     | out_valid_o & out_ready_i
//   config   | cfg_valid_i / cfg_ready_o, index, data    | cfg_valid_i & cfg_ready_o
//
// one request at a time; a load lowers the old label's count when it moves a node
// and raises the new one; an add may be refused on its node labels; a bad label or
// block is answered right after the check; clear walks one memory row per cycle
// over the node store; after reset the same pass runs before the first request
// a result waits in the output register; the next request is taken meanwhile
// config writes are taken in any cycle
// ----------------------------------------------------------------------------
module label_block_sum_accumulator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lbsa_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [lbsa_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [lbsa_pkg::ReqW-1:0]           req_type_i,
  input  logic [lbsa_pkg::NodeW-1:0]          node_row_i,
  input  logic [lbsa_pkg::NodeW-1:0]          node_col_i,
  input  logic [lbsa_pkg::LabelInW-1:0]       label_i,
  input  logic signed [lbsa_pkg::WeightW-1:0] weight_i,
  input  logic [lbsa_pkg::BlockW-1:0]         block_a_i,
  input  logic [lbsa_pkg::BlockW-1:0]         block_b_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [lbsa_pkg::StatusW-1:0]        status_o,
  output logic signed [lbsa_pkg::SumW-1:0]    block_sum_o,
  output logic [lbsa_pkg::PairW-1:0]          pair_count_o
);

  logic [lbsa_pkg::CfgDataW-1:0] labels_q;
  logic                          halve_q;
  lbsa_pkg::cfg_t                cfg;

  lbsa_pkg::node_req_t           node_req;
  lbsa_pkg::cnt_req_t            cnt_req;
  lbsa_pkg::tbl_req_t            tbl_req;
  logic [lbsa_pkg::NodeDw-1:0]   node_rdata;
  logic [lbsa_pkg::CountW-1:0]   cnt_rdata;
  logic [lbsa_pkg::SumW-1:0]     tbl_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      labels_q <= lbsa_pkg::LabelsRst;
      halve_q  <= lbsa_pkg::HalveRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        lbsa_pkg::CFG_LABELS: labels_q <= cfg_data_i;
        lbsa_pkg::CFG_HALVE:  halve_q  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = '{k: lbsa_pkg::eff_labels(labels_q), halve: halve_q};

  lbsa_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .node_row_i   (node_row_i),
    .node_col_i   (node_col_i),
    .label_i      (label_i),
    .weight_i     (weight_i),
    .block_a_i    (block_a_i),
    .block_b_i    (block_b_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .block_sum_o  (block_sum_o),
    .pair_count_o (pair_count_o),
    .node_req_o   (node_req),
    .node_rdata_i (node_rdata),
    .cnt_req_o    (cnt_req),
    .cnt_rdata_i  (cnt_rdata),
    .tbl_req_o    (tbl_req),
    .tbl_rdata_i  (tbl_rdata)
  );

  // valid flag and label per node
  lbsa_ram #(
    .Width (lbsa_pkg::NodeDw),
    .Depth (lbsa_pkg::MaxNodes)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_req.we),
    .waddr_i (node_req.waddr),
    .wdata_i (node_req.wdata),
    .re_i    (node_req.re),
    .raddr_i (node_req.raddr),
    .rdata_o (node_rdata)
  );

  lbsa_ram #(
    .Width (lbsa_pkg::CountW),
    .Depth (lbsa_pkg::MaxLabels)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_req.we),
    .waddr_i (cnt_req.waddr),
    .wdata_i (cnt_req.wdata),
    .re_i    (cnt_req.re),
    .raddr_i (cnt_req.raddr),
    .rdata_o (cnt_rdata)
  );

  lbsa_ram #(
    .Width (lbsa_pkg::SumW),
    .Depth (lbsa_pkg::TblDepth)
  ) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_req.we),
    .waddr_i (tbl_req.waddr),
    .wdata_i (tbl_req.wdata),
    .re_i    (tbl_req.re),
    .raddr_i (tbl_req.raddr),
    .rdata_o (tbl_rdata)
  );

endmodule
